// ===== rtl/core/console_io_port_block_assert.svh =====
// Assertion macros shared by the checker of the console I/O port block.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef CONSOLE_IO_PORT_BLOCK_ASSERT_SVH
`define CONSOLE_IO_PORT_BLOCK_ASSERT_SVH

// Check that prop holds at every clock edge.
`define CIOP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define CIOP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/cioport_pkg.sv =====
// Package of the console I/O port block: port codes, operation codes,
// word types and the byte lane helper. Depends on nothing.
`timescale 1ns / 1ps

package cioport_pkg;

	// Default depth of the GPU byte queue
	localparam int CIOP_FIFO_DEPTH = 16;

	// Operation codes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_VSYNC = 2'd3;

	// Port addresses
	localparam logic [7:0] PORT_KEYPAD  = 8'h80;
	localparam logic [7:0] PORT_TIMER   = 8'h81;
	localparam logic [7:0] PORT_VSYNC   = 8'h82;
	localparam logic [7:0] PORT_ADDR_LO = 8'hb0;
	localparam logic [7:0] PORT_ADDR_HI = 8'hb1;
	localparam logic [7:0] PORT_FLUSH   = 8'hc0;
	localparam logic [7:0] PORT_GPU     = 8'hc1;
	localparam logic [7:0] PORT_PER_LO  = 8'he0;
	localparam logic [7:0] PORT_PER_HI  = 8'he5;
	localparam logic [7:0] PORT_VOL_LO  = 8'hf0;
	localparam logic [7:0] PORT_VOL_HI  = 8'hf5;

	// Wait cycles charged per access
	localparam logic [5:0] WAIT_KEYPAD = 6'd32;
	localparam logic [5:0] WAIT_SOUND  = 6'd16;

	// Widths of the stream words
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 56;

	// One input word
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] port;
		logic [7:0] wdata;
		logic [7:0] buttons;
	} item_t;

	// One result word, apart from the queue read data
	typedef struct packed {
		logic [7:0]  rdata;
		logic [5:0]  wait_added;
		logic        flush_pulse;
		logic        sound_update;
		logic [1:0]  sound_channel;
		logic [15:0] sound_period;
		logic [15:0] sound_volume;
		logic        restart_count;
		logic        fifo_dropped;
	} result_t;

	// Queue requests from the port logic
	typedef struct packed {
		logic       push;
		logic       pop;
		logic [7:0] wdata;
	} fifo_req_t;

	// Queue status toward the port logic
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	// Replace the low byte on an even port, the high byte on an odd port
	function automatic logic [15:0] lane_write(input logic [15:0] old, input logic odd,
			input logic [7:0] data);
		logic [15:0] merged;
		merged = odd ? {data, old[7:0]} : {old[15:8], data};
		return merged;
	endfunction

endpackage

// ===== rtl/core/cioport_in_stage.sv =====
// Input register of the console I/O port block.
// Depends on cioport_pkg for the item type.
`timescale 1ns / 1ps

module cioport_in_stage import cioport_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic take;

	// Take a word when the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload until the next word comes in
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/core/cioport_fifo.sv =====
// GPU byte queue of the console I/O port block: circular buffer in a
// memory array with a registered read port. Depends on cioport_pkg.
`timescale 1ns / 1ps

module cioport_fifo import cioport_pkg::*; #(
	parameter int FIFO_DEPTH = CIOP_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_req_t  req,
	output fifo_stat_t stat,
	output logic [7:0] rd_data
);

	localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CntW = $clog2(FIFO_DEPTH + 1);

	logic [7:0]      mem [FIFO_DEPTH];
	logic [PtrW-1:0] head_q;
	logic [PtrW-1:0] tail_q;
	logic [CntW-1:0] count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CntW'(FIFO_DEPTH));

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (req.push) begin
			tail_q  <= (tail_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			count_q <= count_q + 1'b1;
		end else if (req.pop) begin
			head_q  <= (head_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
			count_q <= count_q - 1'b1;
		end
	end

	// Write at the tail, read the head into the data register
	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[tail_q] <= req.wdata;
		end
		if (req.pop) begin
			rd_data <= mem[head_q];
		end
	end

endmodule

// ===== rtl/core/cioport_core.sv =====
// Port decode and register file of the console I/O port block: tick
// counter, one-shot timer, vsync flag, address and sound registers.
// Depends on cioport_pkg.
`timescale 1ns / 1ps

module cioport_core import cioport_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  logic       fire,
	input  fifo_stat_t fstat,
	output fifo_req_t  freq,
	output result_t    res
);

	logic [31:0] tick_q;
	logic [31:0] target_q;
	logic        vsync_q;
	logic [15:0] addr_q;
	logic [15:0] period_q [3];
	logic [15:0] volume_q [3];

	logic        is_read;
	logic        is_write;
	logic        per_wr;
	logic        vol_wr;
	logic [1:0]  ch;
	logic [15:0] per_new;
	logic [15:0] vol_new;
	logic        expired;

	// Decode the word
	always_comb begin
		is_read  = (item.op == OP_READ);
		is_write = (item.op == OP_WRITE);
		per_wr   = is_write && (item.port inside {[PORT_PER_LO:PORT_PER_HI]});
		vol_wr   = is_write && (item.port inside {[PORT_VOL_LO:PORT_VOL_HI]});
		ch       = item.port[2:1];
		per_new  = per_wr ? lane_write(period_q[ch], item.port[0], item.wdata) : 16'd0;
		vol_new  = vol_wr ? lane_write(volume_q[ch], item.port[0], item.wdata) : 16'd0;
		expired  = (tick_q >= target_q);
	end

	// Queue requests, taken only when the word moves on
	always_comb begin
		freq.push  = fire && is_write && (item.port == PORT_GPU) && !fstat.full;
		freq.pop   = fire && is_read && (item.port == PORT_GPU) && !fstat.empty;
		freq.wdata = item.wdata;
	end

	// Build the result word
	always_comb begin
		res = '0;
		if (is_read) begin
			case (item.port)
				PORT_KEYPAD: begin
					res.rdata      = item.buttons;
					res.wait_added = WAIT_KEYPAD;
				end
				PORT_TIMER: res.rdata = {7'd0, expired};
				PORT_VSYNC: res.rdata = {7'd0, vsync_q};
				default:    res.rdata = 8'd0;
			endcase
		end
		if (is_write) begin
			res.flush_pulse  = (item.port == PORT_FLUSH);
			res.fifo_dropped = (item.port == PORT_GPU) && fstat.full;
			if (per_wr || vol_wr) begin
				res.wait_added    = WAIT_SOUND;
				res.sound_update  = 1'b1;
				res.sound_channel = ch;
				res.sound_period  = per_wr ? per_new : period_q[ch];
				res.sound_volume  = vol_wr ? vol_new : volume_q[ch];
				res.restart_count = per_wr;
			end
		end
	end

	// Update the registers as the word leaves this stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			target_q <= '0;
			vsync_q  <= 1'b0;
			addr_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				period_q[i] <= '0;
				volume_q[i] <= '0;
			end
		end else if (fire) begin
			if (item.op == OP_TICK) begin
				tick_q <= tick_q + 32'd1;
			end
			if (item.op == OP_VSYNC) begin
				vsync_q <= 1'b1;
			end else if (is_read && item.port == PORT_VSYNC) begin
				vsync_q <= 1'b0;
			end
			if (is_write && item.port == PORT_TIMER) begin
				target_q <= tick_q + {24'd0, item.wdata} + 32'd1;
			end
			if (is_write && (item.port == PORT_ADDR_LO || item.port == PORT_ADDR_HI)) begin
				addr_q <= lane_write(addr_q, item.port[0], item.wdata);
			end
			if (per_wr) begin
				period_q[ch] <= per_new;
			end
			if (vol_wr) begin
				volume_q[ch] <= vol_new;
			end
		end
	end

endmodule

// ===== rtl/core/console_io_port_block.sv =====
// Console I/O port block: top level with the input stage, port logic,
// GPU byte queue and the result register.
// Depends on cioport_pkg, cioport_in_stage, cioport_core, cioport_fifo.
//
// Usage:
//   s_axis carries one word per access: tuser holds the operation (read,
//   write, tick, vsync), tdata holds port, write byte and pad buttons.
//   m_axis returns exactly one result word per input word, in order:
//   read byte, wait cycles, flush strobe, sound update, queue drop flag.
//   When the output is free, an accepted word goes through the input
//   register and then the result register, which raises m_axis_tvalid.
//   Throughput is one word per cycle while the receiver takes every
//   result; the port logic between the two registers is a single decode,
//   32-bit add and compare.
//   Reset clears the tick counter, timer, vsync flag, address and sound
//   registers and empties the queue; no clearing pass is needed.
//   When the receiver stalls, the result word holds, the input register
//   fills, and s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps

module console_io_port_block import cioport_pkg::*; #(
	parameter int FIFO_DEPTH = CIOP_FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [7:0] port, [15:8] wdata, [23:16] buttons
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] op
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] rdata, [13:8] wait_added, [14] flush_pulse, [15] sound_update,
	// [17:16] sound_channel, [33:18] sound_period, [49:34] sound_volume,
	// [50] restart_count, [51] fifo_dropped, [55:52] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	item_t      in_item;
	item_t      item_s1;
	logic       valid_s1;
	logic       advance;
	logic       fire;
	fifo_req_t  freq;
	fifo_stat_t fstat;
	result_t    res;
	result_t    res_q;
	logic       fifo_sel_q;
	logic       out_valid_q;
	logic [7:0] fifo_rdata;
	logic [7:0] rdata_out;

	assign in_item.op      = s_axis_tuser;
	assign in_item.port    = s_axis_tdata[7:0];
	assign in_item.wdata   = s_axis_tdata[15:8];
	assign in_item.buttons = s_axis_tdata[23:16];

	// Move a word on when the result register is free or being read
	assign advance = !out_valid_q || m_axis_tready;
	assign fire    = valid_s1 && advance;

	cioport_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	cioport_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (fire),
		.fstat  (fstat),
		.freq   (freq),
		.res    (res)
	);

	cioport_fifo #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (freq),
		.stat    (fstat),
		.rd_data (fifo_rdata)
	);

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q      <= res;
			fifo_sel_q <= freq.pop;
		end
	end

	// Take the read byte from the queue on a queue pop
	assign rdata_out     = fifo_sel_q ? fifo_rdata : res_q.rdata;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, res_q.fifo_dropped, res_q.restart_count,
		res_q.sound_volume, res_q.sound_period, res_q.sound_channel,
		res_q.sound_update, res_q.flush_pulse, res_q.wait_added, rdata_out};

endmodule

// ===== rtl/core/cioport_checker.sv =====
// Port checker of the console I/O port block, bound to the top level.
// Depends on cioport_pkg and console_io_port_block_assert.svh.
`timescale 1ns / 1ps
`include "console_io_port_block_assert.svh"

module cioport_checker import cioport_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic       out_stall;
	logic [5:0] wait_f;
	logic       upd_f;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign wait_f    = m_axis_tdata[13:8];
	assign upd_f     = m_axis_tdata[15];

	// A stalled result word stays valid and unchanged
	`CIOP_ASSERT_NEXT(a_stall_valid, out_stall, m_axis_tvalid, "result dropped under stall")
	`CIOP_ASSERT_NEXT(a_stall_data, out_stall, $stable(m_axis_tdata), "result changed under stall")

	// The wait field only ever holds 0, WAIT_SOUND or WAIT_KEYPAD
	`CIOP_ASSERT(a_wait_codes, !m_axis_tvalid || wait_f == 6'd0 || wait_f == WAIT_SOUND || wait_f == WAIT_KEYPAD, "bad wait count")

	// Sound fields are zero unless a sound register was written
	`CIOP_ASSERT(a_sound_idle, !m_axis_tvalid || upd_f || (m_axis_tdata[50:16] == '0), "sound fields set without update")

	// A full pipeline with a stalled output refuses input
	`CIOP_ASSERT_NEXT(a_backpressure, out_stall && s_axis_tvalid && s_axis_tready && !m_axis_tready, !s_axis_tready || !out_stall, "input taken past a full pipeline")

endmodule

bind console_io_port_block cioport_checker u_cioport_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
